[hw/rtl/assert_macros.svh]
// assertion helpers for the matcher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check, reset disabled
`define CHK_IMPL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication check
`define CHK_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

[hw/rtl/mpsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg
// types and request codes of the multi-pattern string matcher
// ----------------------------------------------------------------------------
package mpsm_pkg;
  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_BUILD   = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;
  localparam logic STATUS_MATCH  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] symbol;
    logic       pattern_end;
  } mpsm_in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  pattern_id;
    logic [31:0] text_position;
    logic        last_of_run;
  } mpsm_out_t;
endpackage

[hw/rtl/mpsm_result_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_result_buf
// one-entry output register that parts the engine from the result channel
// ----------------------------------------------------------------------------
module mpsm_result_buf
  import mpsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mpsm_out_t push_data,
  output logic      full,
  output logic      out_valid,
  output mpsm_out_t out_data,
  input  logic      out_stall
);
  logic vld;
  mpsm_out_t data;
  assign full      = vld && out_stall;
  assign out_valid = vld;
  assign out_data  = data;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (push) begin
      vld <= 1'b1;
    end else if (!out_stall) begin
      vld <= 1'b0;
    end
    if (push) begin
      data <= push_data;
    end
  end
endmodule

[hw/rtl/multi_pattern_string_matcher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_unit
// aho-corasick engine: pattern load, breadth-first build, text scan
// ----------------------------------------------------------------------------
//   channel | signals                   | payload
//   input   | in_valid / in_stall       | mpsm_in_t  (req_type, symbol, end)
//   output  | out_valid / out_stall     | mpsm_out_t (status, id, pos, last)
//
// a pattern symbol is ignored, loaded or rejected, and a rejection waits out
// output stalls; a text symbol walks the suffix chain, checking every pattern
// id at each newly reported node and stopping at an already reported one; the
// single goto and node memory ports (one read a cycle) pace these steps.
// a build clears the reported mark of every node entry; the first build then
// links the root row, and per trie node reads its queue entry and failure
// target, writes its output link and visits each symbol and child.
// after reset a clearing pass over all 2**(node bits + symbol bits) goto entries
// (8192 by default) clears the goto and node memories while no item is accepted.
// a stalled result holds the engine in place; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module multi_pattern_string_matcher_unit
  import mpsm_pkg::*;
#(
  parameter int MAX_NODES     = 256,
  parameter int ALPHABET_SIZE = 32,
  parameter int MAX_PATTERNS  = 16
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  mpsm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mpsm_out_t out_data
);
  localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int SW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int AW = NW + SW;
  localparam int GD = 1 << AW;
  localparam int ND = 1 << NW;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_LD_RD  = 5'd2;
  localparam logic [4:0] S_LD_WT  = 5'd3;
  localparam logic [4:0] S_TX_RD  = 5'd4;
  localparam logic [4:0] S_TX_WT  = 5'd5;
  localparam logic [4:0] S_TX_ND  = 5'd6;
  localparam logic [4:0] S_WK_RD  = 5'd7;
  localparam logic [4:0] S_WK_CK  = 5'd8;
  localparam logic [4:0] S_WK_ID  = 5'd9;
  localparam logic [4:0] S_WK_FIN = 5'd10;
  localparam logic [4:0] S_RJ     = 5'd11;
  localparam logic [4:0] S_RC     = 5'd12;
  localparam logic [4:0] S_BR     = 5'd13;
  localparam logic [4:0] S_BR_WT  = 5'd14;
  localparam logic [4:0] S_BK     = 5'd15;
  localparam logic [4:0] S_BK_Q   = 5'd16;
  localparam logic [4:0] S_BK_F   = 5'd17;
  localparam logic [4:0] S_BK_O   = 5'd18;
  localparam logic [4:0] S_BC_RC  = 5'd19;
  localparam logic [4:0] S_BC_RF  = 5'd20;
  localparam logic [4:0] S_BC_WT  = 5'd21;
  localparam logic [4:0] S_BC_Q   = 5'd22;

  // goto memory: one port, registered read
  logic [NW-1:0] gmem [GD];
  logic [AW-1:0] g_addr;
  logic          g_we;
  logic [NW-1:0] g_wdata, g_rdata;
  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_addr] <= g_wdata;
    end
    g_rdata <= gmem[g_addr];
  end

  // node memory: one read and one write address a cycle, a write enable per
  // field; the breadth-first queue rides along as one more field
  logic          term_m [ND];
  logic          rep_m  [ND];
  logic [NW-1:0] fail_m [ND];
  logic [NW-1:0] outl_m [ND];
  logic [NW-1:0] bq_m   [ND];
  logic [NW-1:0] n_raddr, n_waddr, n_wnode;
  logic          n_wbit;
  logic          n_we_term, n_we_rep, n_we_fail, n_we_out, n_we_q;
  logic          term_rd, rep_rd;
  logic [NW-1:0] fail_rd, outl_rd, bq_rd;
  always_ff @(posedge clk) begin
    if (n_we_term) term_m[n_waddr] <= n_wbit;
    if (n_we_rep)  rep_m[n_waddr]  <= n_wbit;
    if (n_we_fail) fail_m[n_waddr] <= n_wnode;
    if (n_we_out)  outl_m[n_waddr] <= n_wnode;
    if (n_we_q)    bq_m[n_waddr]   <= n_wnode;
    term_rd <= term_m[n_raddr];
    rep_rd  <= rep_m[n_raddr];
    fail_rd <= fail_m[n_raddr];
    outl_rd <= outl_m[n_raddr];
    bq_rd   <= bq_m[n_raddr];
  end

  logic [NW-1:0] pend [MAX_PATTERNS];

  logic [4:0]    state;
  logic [AW:0]   clr_cnt;
  logic [NW:0]   node_count;
  logic [PW:0]   pattern_count;
  logic [NW-1:0] load_node, text_node, walk, walk_nx, bk, bf, child;
  logic [31:0]   pos_cnt, pos_hold;
  logic          built, load_failed, do_bfs;
  mpsm_in_t      req;
  logic [NW:0]   qh, qt;
  logic [SW:0]   ch;
  logic [PW:0]   pid;
  logic [PW-1:0] last_id;
  logic          last_pend;

  logic      push, full;
  mpsm_out_t push_data;

  mpsm_result_buf u_buf (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  assign in_stall = (state != S_IDLE);
  wire take = in_valid && !in_stall;
  wire sym_ok = ({{(32-5){1'b0}}, in_data.symbol} < 32'(ALPHABET_SIZE));
  wire [SW-1:0] rsym = SW'(req.symbol);
  // trie step of a pattern symbol: existing child or a fresh node
  wire ld_rej = (g_rdata == '0) && (node_count >= (NW+1)'(MAX_NODES));
  wire [NW-1:0] ld_child = (g_rdata == '0) ? node_count[NW-1:0] : g_rdata;

  // address mux for the goto memory
  always_comb begin
    g_addr  = '0;
    g_we    = 1'b0;
    g_wdata = '0;
    case (state)
      S_CLR: begin
        g_addr = clr_cnt[AW-1:0];
        g_we   = 1'b1;
      end
      S_LD_RD, S_LD_WT: begin
        g_addr = {load_node, rsym};
        if (state == S_LD_WT && g_rdata == '0 && !ld_rej) begin
          g_we    = 1'b1;
          g_wdata = node_count[NW-1:0];
        end
      end
      S_TX_RD:  g_addr = {text_node, rsym};
      S_BR:     g_addr = {{(NW){1'b0}}, ch[SW-1:0]};
      S_BC_RC:  g_addr = {bk, ch[SW-1:0]};
      S_BC_RF:  g_addr = {bf, ch[SW-1:0]};
      S_BC_WT: begin
        // g_rdata holds goto[f][ch] here; a missing edge copies it
        g_addr = {bk, ch[SW-1:0]};
        if (child == '0) begin
          g_we    = 1'b1;
          g_wdata = g_rdata;
        end
      end
      default: g_addr = '0;
    endcase
  end

  // address mux for the node memory
  always_comb begin
    n_raddr   = '0;
    n_waddr   = '0;
    n_wnode   = '0;
    n_wbit    = 1'b0;
    n_we_term = 1'b0;
    n_we_rep  = 1'b0;
    n_we_fail = 1'b0;
    n_we_out  = 1'b0;
    n_we_q    = 1'b0;
    case (state)
      S_CLR: begin
        n_waddr   = clr_cnt[NW-1:0];
        n_we_term = 1'b1;
        n_we_rep  = 1'b1;
        n_we_fail = 1'b1;
        n_we_out  = 1'b1;
        n_we_q    = 1'b1;
      end
      S_RC: begin
        n_waddr  = clr_cnt[NW-1:0];
        n_we_rep = 1'b1;
      end
      S_LD_WT: begin
        if (!ld_rej && req.pattern_end) begin
          n_waddr   = ld_child;
          n_wbit    = 1'b1;
          n_we_term = 1'b1;
        end
      end
      S_TX_WT: n_raddr = g_rdata;
      S_WK_RD: n_raddr = walk;
      S_WK_CK: begin
        if (!rep_rd) begin
          n_waddr  = walk;
          n_wbit   = 1'b1;
          n_we_rep = 1'b1;
        end
      end
      S_BR_WT: begin
        if (g_rdata != '0 && qt < (NW+1)'(MAX_NODES)) begin
          n_waddr = qt[NW-1:0];
          n_wnode = g_rdata;
          n_we_q  = 1'b1;
        end
      end
      S_BK:    n_raddr = qh[NW-1:0];
      S_BK_Q:  n_raddr = bq_rd;
      S_BK_F:  n_raddr = fail_rd;
      S_BK_O: begin
        // output link from the failure target read in the previous cycle
        n_waddr  = bk;
        n_wnode  = term_rd ? bf : outl_rd;
        n_we_out = 1'b1;
      end
      S_BC_WT: begin
        if (child != '0) begin
          n_waddr   = child;
          n_wnode   = g_rdata;
          n_we_fail = 1'b1;
        end
      end
      S_BC_Q: begin
        if (qt < (NW+1)'(MAX_NODES)) begin
          n_waddr = qt[NW-1:0];
          n_wnode = child;
          n_we_q  = 1'b1;
        end
      end
      default: n_raddr = '0;
    endcase
  end

  always_comb begin
    push = 1'b0;
    push_data = '0;
    if (state == S_RJ) begin
      push = !full;
      push_data.status = STATUS_REJECT;
      push_data.pattern_id = 4'(pattern_count);
      push_data.last_of_run = 1'b1;
    end else if (state == S_WK_FIN && last_pend) begin
      push = !full;
      push_data.status = STATUS_MATCH;
      push_data.pattern_id = 4'(last_id);
      push_data.text_position = pos_hold;
      push_data.last_of_run = 1'b1;
    end else if (state == S_WK_ID && pid < (PW+1)'(MAX_PATTERNS) && pid < pattern_count
                 && pend[pid[PW-1:0]] == walk && last_pend) begin
      // previous match goes out, not last since another follows
      push = !full;
      push_data.status = STATUS_MATCH;
      push_data.pattern_id = 4'(last_id);
      push_data.text_position = pos_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      node_count <= (NW+1)'(1);
      pattern_count <= '0;
      load_node <= '0;
      text_node <= '0;
      pos_cnt <= '0;
      built <= 1'b0;
      load_failed <= 1'b0;
      last_pend <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(GD - 1)) state <= S_IDLE;
        end
        S_IDLE: if (take) begin
          req <= in_data;
          case (in_data.req_type)
            REQ_PATTERN: begin
              if (!built && sym_ok) begin
                if (load_failed) begin
                  if (in_data.pattern_end) load_failed <= 1'b0;
                end else if (pattern_count >= (PW+1)'(MAX_PATTERNS)) begin
                  state <= S_RJ;
                end else begin
                  state <= S_LD_RD;
                end
              end
            end
            REQ_BUILD: begin
              text_node <= '0;
              pos_cnt <= '0;
              load_node <= '0;
              load_failed <= 1'b0;
              // reported marks are cleared first, then the first build links
              clr_cnt <= '0;
              do_bfs <= !built;
              ch <= '0;
              qh <= '0;
              qt <= '0;
              state <= S_RC;
              built <= 1'b1;
            end
            REQ_TEXT: begin
              pos_hold <= pos_cnt;
              pos_cnt <= pos_cnt + 32'd1;
              if (built) begin
                if (sym_ok) state <= S_TX_RD;
                else text_node <= '0;
              end
            end
            default: ;
          endcase
        end
        S_LD_RD: state <= S_LD_WT;
        S_LD_WT: begin
          if (ld_rej) begin
            state <= S_RJ;
          end else begin
            if (g_rdata == '0) node_count <= node_count + 1'b1;
            if (req.pattern_end) begin
              pend[pattern_count[PW-1:0]] <= ld_child;
              pattern_count <= pattern_count + 1'b1;
              load_node <= '0;
            end else begin
              load_node <= ld_child;
            end
            state <= S_IDLE;
          end
        end
        S_RJ: if (!full) begin
          load_node <= '0;
          load_failed <= !req.pattern_end;
          state <= S_IDLE;
        end
        S_TX_RD: state <= S_TX_WT;
        S_TX_WT: begin
          text_node <= g_rdata;
          last_pend <= 1'b0;
          state <= S_TX_ND;
        end
        S_TX_ND: begin
          walk <= term_rd ? text_node : outl_rd;
          state <= S_WK_RD;
        end
        S_WK_RD: begin
          if (walk == '0) begin
            state <= S_WK_FIN;
          end else begin
            state <= S_WK_CK;
          end
        end
        S_WK_CK: begin
          if (rep_rd) begin
            state <= S_WK_FIN;
          end else begin
            walk_nx <= outl_rd;
            pid <= '0;
            state <= S_WK_ID;
          end
        end
        S_WK_ID: begin
          if (pid < (PW+1)'(MAX_PATTERNS) && pid < pattern_count) begin
            if (pend[pid[PW-1:0]] == walk) begin
              if (!last_pend || !full) begin
                last_pend <= 1'b1;
                last_id <= pid[PW-1:0];
                pid <= pid + 1'b1;
              end
            end else begin
              pid <= pid + 1'b1;
            end
          end else begin
            walk <= walk_nx;
            state <= S_WK_RD;
          end
        end
        S_WK_FIN: if (!last_pend || !full) begin
          last_pend <= 1'b0;
          state <= S_IDLE;
        end
        // reported-mark clearing pass on every build
        S_RC: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(ND - 1)) state <= do_bfs ? S_BR : S_IDLE;
        end
        // build: root children first
        S_BR: state <= S_BR_WT;
        S_BR_WT: begin
          if (g_rdata != '0 && qt < (NW+1)'(MAX_NODES)) begin
            qt <= qt + 1'b1;
          end
          if (ch == (SW+1)'(ALPHABET_SIZE - 1)) begin
            state <= S_BK;
          end else begin
            ch <= ch + 1'b1;
            state <= S_BR;
          end
        end
        S_BK: begin
          if (qh >= qt) begin
            state <= S_IDLE;
          end else begin
            qh <= qh + 1'b1;
            state <= S_BK_Q;
          end
        end
        S_BK_Q: begin
          bk <= bq_rd;
          state <= S_BK_F;
        end
        S_BK_F: begin
          bf <= fail_rd;
          state <= S_BK_O;
        end
        S_BK_O: begin
          ch <= '0;
          state <= S_BC_RC;
        end
        S_BC_RC: state <= S_BC_RF;
        S_BC_RF: begin
          child <= g_rdata;
          state <= S_BC_WT;
        end
        S_BC_WT: begin
          if (child != '0) begin
            state <= S_BC_Q;
          end else if (ch == (SW+1)'(ALPHABET_SIZE - 1)) begin
            state <= S_BK;
          end else begin
            ch <= ch + 1'b1;
            state <= S_BC_RC;
          end
        end
        S_BC_Q: begin
          if (qt < (NW+1)'(MAX_NODES)) begin
            qt <= qt + 1'b1;
          end
          if (ch == (SW+1)'(ALPHABET_SIZE - 1)) begin
            state <= S_BK;
          end else begin
            ch <= ch + 1'b1;
            state <= S_BC_RC;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_no_take_busy, clk, rst, state != S_IDLE, !take, "item taken while busy")
  `CHK_IMPL(a_push_room, clk, rst, push, !full, "result pushed into full buffer")
  `CHK_NEXT(a_clr_stall, clk, rst, state == S_CLR, in_stall || state == S_IDLE, "clear pass")
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the multi-pattern string matcher: patterns are
// loaded until the node and pattern stores overflow, the automaton is built
// and text is scanned; every match and rejection is compared with a typed
// expectation row or with an internal aho-corasick predictor
// ----------------------------------------------------------------------------
module testbench
  import mpsm_pkg::*;
();

  localparam int NODES    = 256;
  localparam int ALPHA    = 32;
  localparam int PATTERNS = 16;
  localparam int LIMIT    = 2000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  mpsm_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  mpsm_out_t out_data;

  multi_pattern_string_matcher_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---- predictor state: trie / transition table and scan position
  int          goto_tab [NODES*ALPHA];
  int          fail_lnk [NODES];
  int          out_lnk  [NODES];
  bit          term_mark[NODES];
  bit          seen_mark[NODES];
  int          end_node [PATTERNS];
  int          node_cnt, pat_cnt, load_at, scan_at;
  logic [31:0] scan_pos;
  bit          is_built, dropping;

  mpsm_out_t   new_reports[$];   // reports caused by the last item
  mpsm_out_t   pending_reports[$];
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          sent_cnt;
  bit          quiet;

  // breadth-first failure / output links, completing the goto table
  function automatic void build_links();
    int q[$];
    int k, f, c;
    for (int ch = 0; ch < ALPHA; ch++) begin
      c = goto_tab[ch];
      if (c != 0) begin
        fail_lnk[c] = 0;
        q.insert(q.size(), c);
      end
    end
    while (q.size() > 0) begin
      k = q.pop_front();
      f = fail_lnk[k];
      out_lnk[k] = term_mark[f] ? f : out_lnk[f];
      for (int ch = 0; ch < ALPHA; ch++) begin
        c = goto_tab[k*ALPHA+ch];
        if (c != 0) begin
          fail_lnk[c] = goto_tab[f*ALPHA+ch];
          q.insert(q.size(), c);
        end else begin
          goto_tab[k*ALPHA+ch] = goto_tab[f*ALPHA+ch];
        end
      end
    end
  endfunction

  function automatic void reject_pattern(bit fin);
    mpsm_out_t r;
    r.status = STATUS_REJECT;
    r.pattern_id = pat_cnt[3:0];
    r.text_position = '0;
    r.last_of_run = 1'b1;
    new_reports.insert(new_reports.size(), r);
    load_at = 0;
    dropping = !fin;
  endfunction

  // advance the predictor by one transfer, filling new_reports
  function automatic void predict_matches(mpsm_in_t x);
    int sym, child, u;
    logic [31:0] p;
    mpsm_out_t r;
    new_reports.delete();
    sym = x.symbol;
    case (x.req_type)
      REQ_PATTERN: begin
        if (is_built) return;
        if (dropping) begin
          if (x.pattern_end) dropping = 0;
          return;
        end
        if (pat_cnt >= PATTERNS) begin
          reject_pattern(x.pattern_end);
          return;
        end
        child = goto_tab[load_at*ALPHA+sym];
        if (child == 0) begin
          if (node_cnt >= NODES) begin
            reject_pattern(x.pattern_end);
            return;
          end
          child = node_cnt++;
          goto_tab[load_at*ALPHA+sym] = child;
        end
        load_at = child;
        if (x.pattern_end) begin
          term_mark[load_at] = 1;
          end_node[pat_cnt] = load_at;
          pat_cnt++;
          load_at = 0;
        end
      end
      REQ_BUILD: begin
        if (!is_built) build_links();
        is_built = 1;
        foreach (seen_mark[i]) seen_mark[i] = 0;
        scan_at = 0;
        scan_pos = '0;
        load_at = 0;
        dropping = 0;
      end
      REQ_TEXT: begin
        p = scan_pos;
        scan_pos++;
        if (!is_built) return;
        scan_at = goto_tab[scan_at*ALPHA+sym];
        u = term_mark[scan_at] ? scan_at : out_lnk[scan_at];
        // longest suffix first, ids ascending within a node
        while (u != 0 && !seen_mark[u]) begin
          seen_mark[u] = 1;
          for (int id = 0; id < pat_cnt; id++) begin
            if (end_node[id] == u) begin
              r.status = STATUS_MATCH;
              r.pattern_id = id[3:0];
              r.text_position = p;
              r.last_of_run = 1'b0;
              new_reports.insert(new_reports.size(), r);
            end
          end
          u = out_lnk[u];
        end
        if (new_reports.size() > 0)
          new_reports[new_reports.size()-1].last_of_run = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // one input transfer; typed rows replace the predicted reports
  task automatic send_item(mpsm_in_t x, bit typed = 0, bit has_typed = 0,
                           mpsm_out_t typed_rep = '0);
    bit taken;
    predict_matches(x);
    if (typed) begin
      if (has_typed) pending_reports.insert(pending_reports.size(), typed_rep);
    end else begin
      foreach (new_reports[i]) pending_reports.insert(pending_reports.size(), new_reports[i]);
    end
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent_cnt++;
    quiet = (sent_cnt >= 200 && sent_cnt < 270);
  endtask

  task automatic send_fields(logic [1:0] rq, int sym, bit fin);
    mpsm_in_t x;
    x.req_type = rq;
    x.symbol = sym[4:0];
    x.pattern_end = fin;
    send_item(x);
  endtask

  // ---- result side: random stall, in-order compare
  always @(posedge clk) begin
    mpsm_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result with no expectation: id %0d pos %0d",
                 out_data.pattern_id, out_data.text_position);
          err_cnt++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_data.status);
            err_cnt++;
          end
          if (out_data.pattern_id !== want.pattern_id) begin
            $error("pattern_id: expected %0d actual %0d",
                   want.pattern_id, out_data.pattern_id);
            err_cnt++;
          end
          if (out_data.text_position !== want.text_position) begin
            $error("text_position: expected %0d actual %0d",
                   want.text_position, out_data.text_position);
            err_cnt++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d actual %0d",
                   want.last_of_run, out_data.last_of_run);
            err_cnt++;
          end
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 9);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    mpsm_in_t  item;
    bit        typed;
    bit        has_rep;
    mpsm_out_t rep;
  } stim_row_t;

  localparam mpsm_out_t NO_REP  = '0;
  // pattern store full: id wraps to 0, no position, single result
  localparam mpsm_out_t FULL_REP = '{STATUS_REJECT, 4'd0, 32'd0, 1'b1};

  // short patterns that the text part keeps hitting
  stim_row_t load_rows[] = '{
    '{'{REQ_PATTERN, 5'd1, 1'b0}, 0, 0, NO_REP},   // id 0: 1 2
    '{'{REQ_PATTERN, 5'd2, 1'b1}, 0, 0, NO_REP},
    '{'{REQ_PATTERN, 5'd2, 1'b1}, 0, 0, NO_REP},   // id 1: 2
    '{'{REQ_PATTERN, 5'd2, 1'b1}, 0, 0, NO_REP},   // id 2: duplicate of id 1
    '{'{REQ_PATTERN, 5'd0, 1'b1}, 0, 0, NO_REP},   // id 3: lowest symbol
    '{'{REQ_PATTERN, 5'd31, 1'b0}, 0, 0, NO_REP},  // id 4: highest symbol twice
    '{'{REQ_PATTERN, 5'd31, 1'b1}, 0, 0, NO_REP},
    '{'{REQ_UNUSED, 5'd0, 1'b1}, 1, 0, NO_REP},    // unused code ignored
    '{'{REQ_TEXT, 5'd5, 1'b0}, 1, 0, NO_REP}       // scan before any build
  };

  stim_row_t scan_rows[] = '{
    '{'{REQ_PATTERN, 5'd7, 1'b0}, 1, 1, FULL_REP}, // store full
    '{'{REQ_PATTERN, 5'd8, 1'b0}, 1, 0, NO_REP},   // rest of it discarded
    '{'{REQ_PATTERN, 5'd9, 1'b1}, 1, 0, NO_REP},
    '{'{REQ_PATTERN, 5'd31, 1'b1}, 1, 1, FULL_REP},
    '{'{REQ_TEXT, 5'd1, 1'b0}, 0, 0, NO_REP},
    '{'{REQ_BUILD, 5'd0, 1'b0}, 1, 0, NO_REP},
    '{'{REQ_PATTERN, 5'd3, 1'b1}, 1, 0, NO_REP},   // load after build ignored
    '{'{REQ_TEXT, 5'd1, 1'b0}, 0, 0, NO_REP},
    '{'{REQ_TEXT, 5'd2, 1'b0}, 0, 0, NO_REP},      // 1 2 plus suffix 2 dups
    '{'{REQ_TEXT, 5'd0, 1'b1}, 0, 0, NO_REP},
    '{'{REQ_TEXT, 5'd31, 1'b0}, 0, 0, NO_REP},
    '{'{REQ_TEXT, 5'd31, 1'b0}, 0, 0, NO_REP},
    '{'{REQ_TEXT, 5'd2, 1'b0}, 0, 0, NO_REP},      // already reported
    '{'{REQ_BUILD, 5'd31, 1'b1}, 1, 0, NO_REP},    // repeated build
    '{'{REQ_UNUSED, 5'd31, 1'b1}, 1, 0, NO_REP},
    '{'{REQ_TEXT, 5'd1, 1'b0}, 0, 0, NO_REP},
    '{'{REQ_TEXT, 5'd2, 1'b1}, 0, 0, NO_REP}
  };

  int hot_syms[4] = '{0, 1, 2, 31};

  initial begin
    int len, pick, rnd_cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    sent_cnt = 0;
    quiet = 0;
    foreach (goto_tab[i]) goto_tab[i] = 0;
    foreach (fail_lnk[i]) begin
      fail_lnk[i] = 0; out_lnk[i] = 0; term_mark[i] = 0; seen_mark[i] = 0;
    end
    foreach (end_node[i]) end_node[i] = 0;
    node_cnt = 1; pat_cnt = 0; load_at = 0; scan_at = 0;
    scan_pos = '0; is_built = 0; dropping = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (load_rows[i])
      send_item(load_rows[i].item, load_rows[i].typed, load_rows[i].has_rep,
                load_rows[i].rep);

    // long random patterns until the node or pattern store is full
    while (pat_cnt < PATTERNS && node_cnt < NODES) begin
      len = $urandom_range(20, 40);
      for (int j = 0; j < len; j++)
        send_fields(REQ_PATTERN, $urandom_range(0, ALPHA-1), j == len-1);
    end
    // one more that needs new nodes, then fill ids with duplicates
    if (pat_cnt < PATTERNS) begin
      send_fields(REQ_PATTERN, 5, 0);
      send_fields(REQ_PATTERN, 6, 1);
    end
    while (pat_cnt < PATTERNS) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        send_fields(REQ_PATTERN, 1, 0);
        send_fields(REQ_PATTERN, 2, 1);
      end else begin
        send_fields(REQ_PATTERN, pick == 1 ? 0 : 2, 1);
      end
    end

    // hold off until every rejection has come out
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);
    @(posedge clk);

    foreach (scan_rows[i])
      send_item(scan_rows[i].item, scan_rows[i].typed, scan_rows[i].has_rep,
                scan_rows[i].rep);

    // random text, mostly over the short patterns, with rebuilds
    rnd_cnt = 0;
    while (rnd_cnt < 110) begin
      pick = $urandom_range(99);
      if (pick < 4)
        send_fields(REQ_BUILD, $urandom_range(0, 31), $urandom_range(0, 1));
      else if (pick < 6)
        send_fields(REQ_UNUSED, $urandom_range(0, 31), $urandom_range(0, 1));
      else if (pick < 76)
        send_fields(REQ_TEXT, hot_syms[$urandom_range(0, 3)], $urandom_range(0, 1));
      else
        send_fields(REQ_TEXT, $urandom_range(0, 31), $urandom_range(0, 1));
      rnd_cnt++;
      if (rnd_cnt == 50) begin
        in_valid <= 1'b0;
        wait (pending_reports.size() == 0);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    wait (pending_reports.size() == 0);
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mpsm_pkg.sv
hw/rtl/mpsm_result_buf.sv
hw/rtl/multi_pattern_string_matcher_unit.sv
tb/testbench.sv
